>>> src/differential_odometry_update_assert.svh
`ifndef DIFFERENTIAL_ODOMETRY_UPDATE_ASSERT_SVH
`define DIFFERENTIAL_ODOMETRY_UPDATE_ASSERT_SVH
// implication in the same cycle
`define DOU_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dou assertion failed");
// implication in the next cycle
`define DOU_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dou assertion failed");
`endif

>>> src/dou_pkg.sv
package dou_pkg;
  localparam int COUNT_WIDTH  = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

  localparam logic signed [33:0] PI_Q29      = 34'sd1686629713;
  localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314857;
  localparam logic signed [33:0] TWO_PI_Q29  = 34'sd3373259426;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  localparam logic [31:0] COUNT_SCALE_RST = 32'd69578;
  localparam logic [23:0] INV_TRACK_RST   = 24'd233060;
  localparam logic [15:0] SAMPLE_RATE_RST = 16'd250;

  typedef enum logic [1:0] {
    CFG_COUNT_SCALE = 2'd0,
    CFG_INV_TRACK   = 2'd1,
    CFG_SAMPLE_RATE = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MR, S_ML, S_DIFF, S_PH, S_PL, S_PROD, S_CWAIT,
    S_MX, S_MY, S_LS, S_AS, S_DONE
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    if (v > 67'sd2147483647) return 32'sh7fffffff;
    if (v < -67'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [33:0] atan_q29(input logic [4:0] i);
    case (i)
      5'd0:  return 34'sd421657428;
      5'd1:  return 34'sd248918915;
      5'd2:  return 34'sd131521918;
      5'd3:  return 34'sd66762579;
      5'd4:  return 34'sd33510843;
      5'd5:  return 34'sd16771758;
      5'd6:  return 34'sd8387925;
      5'd7:  return 34'sd4194219;
      5'd8:  return 34'sd2097141;
      5'd9:  return 34'sd1048575;
      default: return 34'sd1 <<< (5'd29 - i);
    endcase
  endfunction
endpackage

>>> src/dou_in_if.sv
interface dou_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] right_count;
  logic signed [31:0] left_count;
  modport source(output valid, right_count, left_count, input ready);
  modport sink(input valid, right_count, left_count, output ready);
endinterface

>>> src/dou_out_if.sv
interface dou_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_out;
  logic signed [31:0] y_out;
  logic signed [31:0] heading_out;
  logic signed [31:0] linear_speed;
  logic signed [31:0] angular_speed;
  modport source(output valid, x_out, y_out, heading_out, linear_speed, angular_speed,
                 input ready);
  modport sink(input valid, x_out, y_out, heading_out, linear_speed, angular_speed,
               output ready);
endinterface

>>> src/differential_odometry_update.sv
// Differential-drive odometry. Each sample transaction carries the right and left
// encoder counts; one result transaction follows with the pose (x, y in Q16.16,
// heading in Q3.29 within +-pi) and the linear and angular speeds (Q16.16,
// saturated). The next sample can be accepted in the same cycle as its result
// appears. A 16-step CORDIC for sin/cos of the heading starts at acceptance and
// runs alongside the first passes of eight through one shared 33x33 multiplier;
// the wait for the CORDIC sets the length of a transaction. A result that is not
// taken holds the next one in its last step and stalls the input.
// Configuration registers (0 count_scale, 1 inverse_track_width, 2 sample_rate)
// are to be written by the user only while the block is idle; the block itself
// does not enforce this.
module differential_odometry_update
  import dou_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  dou_in_if.sink      sample,
  dou_out_if.source   pose,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  state_t state, state_next;

  logic [31:0] count_scale;
  logic [23:0] inv_track;
  logic [15:0] sample_rate;

  logic [COUNT_WIDTH-1:0] prev_right, prev_left, d_r, d_l;
  logic signed [31:0] dr, dl, x_pos, y_pos, heading, dsp, lin;
  logic signed [47:0] dist_r, dist_l;
  logic signed [39:0] diff, diff_c;
  logic signed [44:0] phi;
  logic signed [63:0] prod;
  logic signed [66:0] negp;
  logic signed [48:0] sum, dd;
  logic signed [31:0] angq;
  logic signed [60:0] pr3;
  logic signed [33:0] dth, h0, hw;

  logic signed [32:0] ma, mb;
  logic signed [65:0] p;
  logic               cbusy, accept;
  logic signed [32:0] sn, cs;

  dou_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(p));

  dou_cordic u_cordic (
    .clk(clk), .rst(rst), .start(accept), .angle(heading),
    .busy(cbusy), .sn(sn), .cs(cs)
  );

  assign sample.ready = (state == S_IDLE);
  assign accept       = sample.valid && sample.ready;

  assign d_r = sample.right_count[COUNT_WIDTH-1:0] - prev_right;
  assign d_l = sample.left_count[COUNT_WIDTH-1:0] - prev_left;

  assign negp   = -67'(p);
  assign dist_l = negp[63:16];
  assign sum    = 49'(dist_r) + 49'(dist_l);
  assign dd     = 49'(dist_r) - 49'(dist_l);
  always_comb begin
    if (dd > 49'sd274877906944) diff_c = 40'sd274877906944;
    else if (dd < -49'sd274877906944) diff_c = -40'sd274877906944;
    else diff_c = dd[39:0];
  end

  assign angq = sat32(67'(signed'(prod[63:16])));
  assign pr3  = prod[63:3];
  always_comb begin
    if (pr3 > 61'(PI_Q29)) dth = PI_Q29;
    else if (pr3 < -61'(PI_Q29)) dth = -PI_Q29;
    else dth = pr3[33:0];
    h0 = 34'(heading) + dth;
    if (h0 > PI_Q29) hw = h0 - TWO_PI_Q29;
    else if (h0 < -PI_Q29) hw = h0 + TWO_PI_Q29;
    else hw = h0;
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_MR: begin ma = 33'(dr); mb = {1'b0, count_scale}; end
      S_ML: begin ma = 33'(dl); mb = {1'b0, count_scale}; end
      S_PH: begin ma = 33'(signed'(diff[39:20])); mb = {9'b0, inv_track}; end
      S_PL: begin ma = {13'b0, diff[19:0]}; mb = {9'b0, inv_track}; end
      S_MX: begin ma = 33'(dsp); mb = sn; end
      S_MY: begin ma = 33'(dsp); mb = cs; end
      S_LS: begin ma = 33'(dsp); mb = {17'b0, sample_rate}; end
      S_AS, S_DONE: begin ma = 33'(angq); mb = {17'b0, sample_rate}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_MR;
      S_MR:    state_next = S_ML;
      S_ML:    state_next = S_DIFF;
      S_DIFF:  state_next = S_PH;
      S_PH:    state_next = S_PL;
      S_PL:    state_next = S_PROD;
      S_PROD:  state_next = S_CWAIT;
      S_CWAIT: if (!cbusy) state_next = S_MX;
      S_MX:    state_next = S_MY;
      S_MY:    state_next = S_LS;
      S_LS:    state_next = S_AS;
      S_AS:    state_next = S_DONE;
      S_DONE:  if (!pose.valid || pose.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_scale <= COUNT_SCALE_RST;
      inv_track   <= INV_TRACK_RST;
      sample_rate <= SAMPLE_RATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COUNT_SCALE: count_scale <= cfg_data;
        CFG_INV_TRACK:   inv_track   <= cfg_data[23:0];
        CFG_SAMPLE_RATE: sample_rate <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_right <= '0;
      prev_left  <= '0;
      x_pos      <= '0;
      y_pos      <= '0;
      heading    <= '0;
      pose.valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!pose.valid || pose.ready)) pose.valid <= 1'b1;
      else if (pose.ready) pose.valid <= 1'b0;
      case (state)
        S_IDLE: if (accept) begin
          prev_right <= sample.right_count[COUNT_WIDTH-1:0];
          prev_left  <= sample.left_count[COUNT_WIDTH-1:0];
        end
        S_MY: x_pos <= sat32(67'(x_pos) + 67'(signed'(p[65:30])));
        S_LS: y_pos <= sat32(67'(y_pos) + 67'(signed'(p[65:30])));
        S_AS: heading <= hw[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        dr <= 32'(signed'(d_r));
        dl <= 32'(signed'(d_l));
      end
      S_ML:   dist_r <= p[63:16];
      S_DIFF: begin
        dsp  <= sat32(67'(signed'(sum[48:1])));
        diff <= diff_c;
      end
      S_PL:   phi <= p[44:0];
      S_PROD: prod <= 64'({phi, 20'b0}) + {20'b0, p[43:0]};
      S_AS:   lin <= sat32(67'(p));
      S_DONE: if (!pose.valid || pose.ready) begin
        pose.x_out         <= x_pos;
        pose.y_out         <= y_pos;
        pose.heading_out   <= heading;
        pose.linear_speed  <= lin;
        pose.angular_speed <= sat32(67'(p));
      end
      default: ;
    endcase
  end
endmodule

>>> src/dou_mul.sv
module dou_mul
  import dou_pkg::*;
(
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

>>> src/dou_cordic.sv
module dou_cordic
  import dou_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               busy,
  output logic signed [32:0] sn,
  output logic signed [32:0] cs
);
  logic signed [33:0] x, y, z, a34;
  logic signed [33:0] xs, ys, at;
  logic               flip;
  logic [STEP_W-1:0]  step;

  assign a34 = 34'(angle);
  assign xs  = x >>> step;
  assign ys  = y >>> step;
  assign at  = atan_q29(5'(step));
  assign sn  = flip ? -33'(y) : 33'(y);
  assign cs  = flip ? -33'(x) : 33'(x);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == STEP_W'(CORDIC_STEPS - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= GAIN_Q30;
      y <= '0;
      if (a34 > HALF_PI_Q29) begin
        z <= a34 - PI_Q29; flip <= 1'b1;
      end else if (a34 < -HALF_PI_Q29) begin
        z <= a34 + PI_Q29; flip <= 1'b1;
      end else begin
        z <= a34; flip <= 1'b0;
      end
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - ys; y <= y + xs; z <= z - at;
      end else begin
        x <= x + ys; y <= y - xs; z <= z + at;
      end
    end
  end
endmodule

>>> src/dou_checker.sv
`include "differential_odometry_update_assert.svh"
module dou_checker
  import dou_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] heading_out
);
  `DOU_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `DOU_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `DOU_ASSERT_NOW(a_heading_range, clk, rst, out_valid, (34'(heading_out) <= PI_Q29) && (34'(heading_out) >= -PI_Q29))
  `DOU_ASSERT_NXT(a_no_instant_result, clk, rst, in_valid && in_ready, !$rose(out_valid))
endmodule

bind differential_odometry_update dou_checker u_dou_checker (
  .clk(clk), .rst(rst),
  .in_valid(sample.valid), .in_ready(sample.ready),
  .out_valid(pose.valid), .out_ready(pose.ready),
  .heading_out(pose.heading_out)
);

>>> bench/tb_differential_odometry_update.sv
module tb_differential_odometry_update;
  import dou_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam longint ATAN_Q29 [30] = '{
    421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
    8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1
  };

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] hdg;
    logic signed [31:0] lin;
    logic signed [31:0] ang;
  } pose_t;

  class odo_scoreboard;
    bit [31:0] scale;
    bit [23:0] inv_track;
    bit [15:0] rate;
    bit [31:0] last_r;
    bit [31:0] last_l;
    longint    x_acc;
    longint    y_acc;
    longint    hdg_acc;
    pose_t     pose_q[$];
    int        errors;

    function new();
      scale = COUNT_SCALE_RST;
      inv_track = INV_TRACK_RST;
      rate = SAMPLE_RATE_RST;
      last_r = 0;
      last_l = 0;
      x_acc = 0;
      y_acc = 0;
      hdg_acc = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        CFG_COUNT_SCALE: scale = v;
        CFG_INV_TRACK:   inv_track = v[23:0];
        CFG_SAMPLE_RATE: rate = v[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pose_q.size();
    endfunction

    function longint lim(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint sat(longint v);
      return lim(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function void rotate(longint ang, output longint sn, output longint cs);
      longint cx, cy, cz, xs, ys;
      bit     flip;
      cx = longint'(GAIN_Q30);
      cy = 0;
      cz = ang;
      flip = 0;
      if (cz > longint'(HALF_PI_Q29)) begin
        cz -= longint'(PI_Q29);
        flip = 1;
      end else if (cz < -longint'(HALF_PI_Q29)) begin
        cz += longint'(PI_Q29);
        flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
        xs = cx >>> i;
        ys = cy >>> i;
        if (cz >= 0) begin
          cx -= ys; cy += xs; cz -= ATAN_Q29[i];
        end else begin
          cx += ys; cy -= xs; cz += ATAN_Q29[i];
        end
      end
      sn = flip ? -cy : cy;
      cs = flip ? -cx : cx;
    endfunction

    function void note(bit [31:0] r, bit [31:0] l);
      bit [31:0] d;
      longint dr, dl, dist_r, dist_l, ds, diff, prod, dth, h, sn, cs, dsp, pi;
      pose_t  p;
      pi = longint'(PI_Q29);
      d = r - last_r;
      dr = longint'($signed(d));
      d = l - last_l;
      dl = longint'($signed(d));
      last_r = r;
      last_l = l;
      dist_r = (dr * longint'(scale)) >>> 16;
      dist_l = (-(dl * longint'(scale))) >>> 16;
      ds = (dist_r + dist_l) >>> 1;
      diff = lim(dist_r - dist_l, -(64'sd1 <<< 38), 64'sd1 <<< 38);
      prod = diff * longint'(inv_track);
      rotate(hdg_acc, sn, cs);
      dsp = sat(ds);
      x_acc = sat(x_acc + ((dsp * sn) >>> 30));
      y_acc = sat(y_acc + ((dsp * cs) >>> 30));
      dth = lim(prod >>> 3, -pi, pi);
      h = hdg_acc + dth;
      if (h > pi) h -= longint'(TWO_PI_Q29);
      if (h < -pi) h += longint'(TWO_PI_Q29);
      hdg_acc = h;
      p.x = x_acc[31:0];
      p.y = y_acc[31:0];
      p.hdg = hdg_acc[31:0];
      p.lin = sat(ds * longint'(rate));
      p.ang = sat((prod >>> 16) * longint'(rate));
      pose_q.push_back(p);
    endfunction

    function void check(pose_t got);
      pose_t e;
      if (pose_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pose transaction x=%0d", got.x);
        return;
      end
      e = pose_q.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("pose mismatch: exp x=%0d y=%0d h=%0d v=%0d w=%0d got %0d %0d %0d %0d %0d",
                   e.x, e.y, e.hdg, e.lin, e.ang,
                   got.x, got.y, got.hdg, got.lin, got.ang);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;
  bit          calm = 0;
  bit          hold_req = 0;
  bit          hold_seen = 0;
  int          hold_left = 0;
  bit [31:0]   cur_r = 0;
  bit [31:0]   cur_l = 0;
  odo_scoreboard sb = new();

  dou_in_if  sample();
  dou_out_if pose();

  differential_odometry_update dut (
    .clk(clk), .rst(rst), .sample(sample), .pose(pose),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    sample.valid = 0;
    sample.right_count = 0;
    sample.left_count = 0;
    pose.ready = 0;
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      pose.ready <= 0;
    end else if (hold_req && !hold_seen) begin
      hold_seen <= 1;
      hold_left <= 400;
      pose.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pose.ready <= 0;
    end else begin
      pose.ready <= calm || ($urandom_range(99) >= 28);
    end
  end

  always @(posedge clk) begin
    pose_t got;
    if (!rst && pose.valid && pose.ready) begin
      got.x = pose.x_out;
      got.y = pose.y_out;
      got.hdg = pose.heading_out;
      got.lin = pose.linear_speed;
      got.ang = pose.angular_speed;
      sb.check(got);
    end
  end

  task automatic send_tick(bit [31:0] r, bit [31:0] l);
    while (!calm && $urandom_range(99) < 28) begin
      sample.valid <= 0;
      @(posedge clk);
    end
    sample.valid <= 1;
    sample.right_count <= r;
    sample.left_count <= l;
    do @(posedge clk); while (!sample.ready);
    sb.note(r, l);
    cur_r = r;
    cur_l = l;
  endtask

  task automatic wait_idle();
    sample.valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] v);
    wait_idle();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic random_tick();
    int sel;
    int dr;
    int dl;
    sel = $urandom_range(99);
    if (sel < 8) begin
      send_tick($urandom, $urandom);
    end else if (sel < 15) begin
      dr = $urandom_range(2097152) - 1048576;
      dl = $urandom_range(2097152) - 1048576;
      send_tick(cur_r + dr, cur_l + dl);
    end else begin
      dr = $urandom_range(6000) - 3000;
      dl = (sel < 40) ? -dr : $urandom_range(6000) - 3000;
      send_tick(cur_r + dr, cur_l + dl);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_tick(0, 0);
    send_tick(1000, 1000);
    send_tick(2000, 0);
    send_tick(32'h7fffffff, 32'h80000000);
    send_tick(32'h80000000, 32'h7fffffff);
    send_tick(32'hffffffff, 32'hffffffff);
    send_tick(32'h00000005, 32'h00000005);
    send_tick(32'h80000000, 32'h80000000);
    send_tick(32'h7ffffff0, 32'h7ffffff0);
    send_tick(32'h80000010, 32'h80000010);
    send_tick(32'h80000100, 32'h7fffff00);
    cfg_write(CFG_COUNT_SCALE, 32'hffffffff);
    cfg_write(CFG_INV_TRACK, 32'h00ffffff);
    cfg_write(CFG_SAMPLE_RATE, 32'h0000ffff);
    send_tick(32'h00000000, 32'h00000000);
    send_tick(32'h7fffffff, 32'h80000001);
    send_tick(32'h00000000, 32'h00000000);
    send_tick(32'h40000000, 32'h40000000);
    cfg_write(CFG_SAMPLE_RATE, 32'h0);
    send_tick(32'h40001000, 32'h3ffff000);
    cfg_write(CFG_UNUSED, 32'h12345678);
    send_tick(32'h40002000, 32'h3fffe000);

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          cfg_write(CFG_COUNT_SCALE, COUNT_SCALE_RST);
          cfg_write(CFG_INV_TRACK, INV_TRACK_RST);
          cfg_write(CFG_SAMPLE_RATE, SAMPLE_RATE_RST);
        end
        1: begin
          cfg_write(CFG_COUNT_SCALE, 32'hffffffff);
          cfg_write(CFG_SAMPLE_RATE, 32'h1);
        end
        2: begin
          cfg_write(CFG_COUNT_SCALE, 32'h0);
          cfg_write(CFG_INV_TRACK, 32'h0);
        end
        3: begin
          cfg_write(CFG_COUNT_SCALE, $urandom);
          cfg_write(CFG_INV_TRACK, $urandom_range(24'hffffff));
          cfg_write(CFG_SAMPLE_RATE, $urandom_range(65535, 1));
        end
        4: begin
          cfg_write(CFG_COUNT_SCALE, $urandom_range(400000));
          cfg_write(CFG_INV_TRACK, 32'h00ffffff);
          cfg_write(CFG_SAMPLE_RATE, 32'h0000ffff);
        end
        5: begin
          cfg_write(CFG_COUNT_SCALE, 32'd69578);
          cfg_write(CFG_INV_TRACK, $urandom_range(2000000));
          cfg_write(CFG_SAMPLE_RATE, $urandom_range(1000, 1));
        end
        default: cfg_write(CFG_SAMPLE_RATE, 32'd250);
      endcase
      for (int n = 0; n < 97; n++) begin
        calm = (ph == 2 && n < 60);
        if (ph == 3 && n == 10) hold_req = 1;
        if (ph == 4 && n == 50) wait_idle();
        random_tick();
      end
      calm = 0;
    end

    wait_idle();
    if (sb.errors == 0)
      $display("differential_odometry_update test passed");
    else
      $display("differential_odometry_update test failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("differential_odometry_update test failed");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+src
src/dou_pkg.sv
src/dou_in_if.sv
src/dou_out_if.sv
src/dou_mul.sv
src/dou_cordic.sv
src/differential_odometry_update.sv
src/dou_checker.sv
bench/tb_differential_odometry_update.sv
